/* design/complex_arithmetic_unit_defines.svh */
// Assertion macros for the complex arithmetic unit checker.
// Needs signals clk and arst_n in the scope of use.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define CAU_CHECK(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define CAU_CHECK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/cau_pkg.sv */
// Shared types for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

	typedef enum logic [3:0] {
		CMD_ADD    = 4'd0,
		CMD_SUB    = 4'd1,
		CMD_MUL    = 4'd2,
		CMD_DIV    = 4'd3,
		CMD_MAG_LT = 4'd4,
		CMD_MAG_LE = 4'd5,
		CMD_MAG_GT = 4'd6,
		CMD_MAG_GE = 4'd7,
		CMD_MAG_EQ = 4'd8,
		CMD_MAG_NE = 4'd9,
		CMD_EQ     = 4'd10,
		CMD_NE     = 4'd11,
		CMD_OR     = 4'd12,
		CMD_AND    = 4'd13
	} cmd_t;

	// divider side flags
	typedef struct packed {
		logic neg;   // quotient is negative
		logic ovf;   // quotient magnitude does not fit the component width
	} div_flags_t;

endpackage

/* design/cau_div.sv */
// Pipelined restoring divider: |num| * 2^F / den, one quotient bit per stage.
// Uses cau_pkg (div_flags_t). A registered prep stage, then the bit stages; advances on en.
module cau_div #(
	parameter int W = 16,
	parameter int F = 8
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [2*W:0]    num,
	input  logic        [2*W:0]    den,
	output logic        [W-1:0]    q_mag,
	output cau_pkg::div_flags_t    flags
);

	localparam int XW = 3*W + F + 2;

	logic [XW-1:0]       rem_s [0:W];
	logic [2*W:0]        den_s [0:W];
	logic [W-1:0]        q_s   [0:W];
	cau_pkg::div_flags_t fl_s  [0:W];

	logic [2*W:0]  mag;
	logic [XW-1:0] dvd;

	always_comb begin
		mag = num[2*W] ? (2*W+1)'(-num) : num;
		dvd = XW'(mag) << F;
	end

	// prep stage: magnitude, sign, range check
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]     <= dvd;
			den_s[0]     <= den;
			q_s[0]       <= '0;
			fl_s[0].neg  <= num[2*W];
			fl_s[0].ovf  <= dvd >= (XW'(den) << W);
		end
	end

	for (genvar k = 1; k <= W; k++) begin : g_bit
		logic [XW-1:0] trial;
		logic          take;
		always_comb begin
			trial = XW'(den_s[k-1]) << (W - k);
			take  = rem_s[k-1] >= trial;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? rem_s[k-1] - trial : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				q_s[k]   <= q_s[k-1] | (W'(take) << (W - k));
				fl_s[k]  <= fl_s[k-1];
			end
		end
	end

	assign q_mag = q_s[W];
	assign flags = fl_s[W];

endmodule

/* design/complex_arithmetic_unit.sv */
// Complex arithmetic unit: add/sub/mul/div and tests on two complex operands.
// Uses cau_pkg and the cau_div pipelined divider.
//
// Input channel: in_valid/in_stall carry command, a_re, a_im, b_re, b_im.
// Output channel: out_valid/out_stall carry res_re, res_im, truth,
// div_zero, saturated. A word moves when valid is high and stall is low.
// Components are signed fixed point, COMPONENT_WIDTH bits with
// FRACTION_BITS fraction bits (Q8.8 by default).
// The restoring divider, one quotient bit per stage, sets the depth.
// Throughput: one word per cycle while the output is not stalled; every command takes the same path.
// Reset clears the valid bits only; the output is empty afterwards.
// When the receiver stalls a full output register, the whole pipeline
// freezes and in_stall rises in the same cycle; nothing is lost or repeated.
// Commands 14 and 15 give an all-zero result word.
module complex_arithmetic_unit #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int FRACTION_BITS   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [3:0]                        command,
	input  logic signed [COMPONENT_WIDTH-1:0] a_re,
	input  logic signed [COMPONENT_WIDTH-1:0] a_im,
	input  logic signed [COMPONENT_WIDTH-1:0] b_re,
	input  logic signed [COMPONENT_WIDTH-1:0] b_im,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [COMPONENT_WIDTH-1:0] res_re,
	output logic signed [COMPONENT_WIDTH-1:0] res_im,
	output logic                              truth,
	output logic                              div_zero,
	output logic                              saturated
);

	localparam int W  = COMPONENT_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int LW = 2*W + 2;
	localparam logic signed [LW-1:0] CHI = LW'((64'sd1 <<< (W-1)) - 64'sd1);
	localparam logic signed [LW-1:0] CLO = -CHI - LW'(1);

	// word riding alongside the divider
	typedef struct packed {
		logic         is_div;
		logic         dz;
		logic         truth;
		logic         sat;
		logic [W-1:0] re;
		logic [W-1:0] im;
	} side_t;

	// clamp to component range, result is {clamped, value}
	function automatic logic [W:0] clampv(input logic signed [LW-1:0] v);
		logic [W:0] r;
		if (v > CHI)      r = {1'b1, CHI[W-1:0]};
		else if (v < CLO) r = {1'b1, CLO[W-1:0]};
		else              r = {1'b0, v[W-1:0]};
		return r;
	endfunction

	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: products, add/sub, exact equality
	logic                v_s1;
	cau_pkg::cmd_t       cmd_s1;
	logic signed [2*W-1:0] prr_s1, pii_s1, pri_s1, pir_s1;
	logic signed [2*W-1:0] sar_s1, sai_s1, sbr_s1, sbi_s1;
	logic signed [W:0]   addr_s1, addi_s1, subr_s1, subi_s1;
	logic                eq_s1, anz_s1, bnz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= cau_pkg::cmd_t'(command);
			prr_s1  <= a_re * b_re;
			pii_s1  <= a_im * b_im;
			pri_s1  <= a_re * b_im;
			pir_s1  <= a_im * b_re;
			sar_s1  <= a_re * a_re;
			sai_s1  <= a_im * a_im;
			sbr_s1  <= b_re * b_re;
			sbi_s1  <= b_im * b_im;
			addr_s1 <= (W+1)'(a_re) + (W+1)'(b_re);
			addi_s1 <= (W+1)'(a_im) + (W+1)'(b_im);
			subr_s1 <= (W+1)'(a_re) - (W+1)'(b_re);
			subi_s1 <= (W+1)'(a_im) - (W+1)'(b_im);
			eq_s1   <= (a_re == b_re) && (a_im == b_im);
			anz_s1  <= (a_re != '0) || (a_im != '0);
			bnz_s1  <= (b_re != '0) || (b_im != '0);
		end
	end

	// stage 2: sums of products
	logic                v_s2;
	cau_pkg::cmd_t       cmd_s2;
	logic signed [2*W:0] mulr_s2, muli_s2, numr_s2, numi_s2;
	logic        [2*W:0] ma_s2, mb_s2;
	logic signed [W:0]   addr_s2, addi_s2, subr_s2, subi_s2;
	logic                eq_s2, anz_s2, bnz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2  <= cmd_s1;
			mulr_s2 <= (2*W+1)'(prr_s1) - (2*W+1)'(pii_s1);
			muli_s2 <= (2*W+1)'(pri_s1) + (2*W+1)'(pir_s1);
			numr_s2 <= (2*W+1)'(prr_s1) + (2*W+1)'(pii_s1);
			numi_s2 <= (2*W+1)'(pir_s1) - (2*W+1)'(pri_s1);
			ma_s2   <= {1'b0, sar_s1} + {1'b0, sai_s1};
			mb_s2   <= {1'b0, sbr_s1} + {1'b0, sbi_s1};
			addr_s2 <= addr_s1;
			addi_s2 <= addi_s1;
			subr_s2 <= subr_s1;
			subi_s2 <= subi_s1;
			eq_s2   <= eq_s1;
			anz_s2  <= anz_s1;
			bnz_s2  <= bnz_s1;
		end
	end

	// stage 3: everything but the quotient is settled here
	side_t side_d;
	logic [W:0] cr, ci;

	always_comb begin
		side_d = '0;
		cr     = '0;
		ci     = '0;
		case (cmd_s2)
			cau_pkg::CMD_ADD: begin
				cr = clampv(LW'(addr_s2));
				ci = clampv(LW'(addi_s2));
			end
			cau_pkg::CMD_SUB: begin
				cr = clampv(LW'(subr_s2));
				ci = clampv(LW'(subi_s2));
			end
			cau_pkg::CMD_MUL: begin
				cr = clampv(LW'(mulr_s2 >>> F));
				ci = clampv(LW'(muli_s2 >>> F));
			end
			cau_pkg::CMD_DIV: begin
				side_d.is_div = 1'b1;
				side_d.dz     = (mb_s2 == '0);
			end
			cau_pkg::CMD_MAG_LT: side_d.truth = ma_s2 <  mb_s2;
			cau_pkg::CMD_MAG_LE: side_d.truth = ma_s2 <= mb_s2;
			cau_pkg::CMD_MAG_GT: side_d.truth = ma_s2 >  mb_s2;
			cau_pkg::CMD_MAG_GE: side_d.truth = ma_s2 >= mb_s2;
			cau_pkg::CMD_MAG_EQ: side_d.truth = ma_s2 == mb_s2;
			cau_pkg::CMD_MAG_NE: side_d.truth = ma_s2 != mb_s2;
			cau_pkg::CMD_EQ:     side_d.truth = eq_s2;
			cau_pkg::CMD_NE:     side_d.truth = !eq_s2;
			cau_pkg::CMD_OR:     side_d.truth = anz_s2 || bnz_s2;
			cau_pkg::CMD_AND:    side_d.truth = anz_s2 && bnz_s2;
			default: ;
		endcase
		side_d.sat = cr[W] | ci[W];
		side_d.re  = cr[W-1:0];
		side_d.im  = ci[W-1:0];
	end

	// delay line matched to the divider depth
	side_t side_s [0:W];
	logic  [W:0] v_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sd <= '0;
		else if (en) v_sd <= {v_sd[W-1:0], v_s2};
	end

	always_ff @(posedge clk) begin
		if (en) side_s[0] <= side_d;
	end

	for (genvar k = 1; k <= W; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) side_s[k] <= side_s[k-1];
		end
	end

	// dividers for both components, den = |b|^2
	logic [W-1:0]        qr_mag, qi_mag;
	cau_pkg::div_flags_t qr_fl, qi_fl;

	cau_div #(.W(W), .F(F)) u_div_re (
		.clk   (clk),
		.en    (en),
		.num   (numr_s2),
		.den   (mb_s2),
		.q_mag (qr_mag),
		.flags (qr_fl)
	);

	cau_div #(.W(W), .F(F)) u_div_im (
		.clk   (clk),
		.en    (en),
		.num   (numi_s2),
		.den   (mb_s2),
		.q_mag (qi_mag),
		.flags (qi_fl)
	);

	// signed, clamped quotient: {clamped, value}
	function automatic logic [W:0] qfix(input logic [W-1:0] m,
			input cau_pkg::div_flags_t fl);
		logic big;
		logic [W:0] r;
		big = fl.neg ? (m[W-1] && (m[W-2:0] != '0)) : m[W-1];
		if (fl.ovf || big) r = {1'b1, fl.neg ? CLO[W-1:0] : CHI[W-1:0]};
		else               r = {1'b0, fl.neg ? W'(-m) : m};
		return r;
	endfunction

	logic [W:0] qr, qi;
	side_t      fin;

	always_comb begin
		qr  = qfix(qr_mag, qr_fl);
		qi  = qfix(qi_mag, qi_fl);
		fin = side_s[W];
		if (fin.is_div && !fin.dz) begin
			fin.re  = qr[W-1:0];
			fin.im  = qi[W-1:0];
			fin.sat = qr[W] | qi[W];
		end
	end

	// output register
	logic         out_valid_q;
	logic [W-1:0] re_q, im_q;
	logic         truth_q, dz_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v_sd[W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q    <= fin.re;
			im_q    <= fin.im;
			truth_q <= fin.truth;
			dz_q    <= fin.dz;
			sat_q   <= fin.sat;
		end
	end

	assign out_valid = out_valid_q;
	assign res_re    = re_q;
	assign res_im    = im_q;
	assign truth     = truth_q;
	assign div_zero  = dz_q;
	assign saturated = sat_q;

endmodule

/* design/cau_checker.sv */
// Port-level checks for the complex arithmetic unit, bound to its top level.
// Uses complex_arithmetic_unit_defines.svh for the assertion macros.
`include "complex_arithmetic_unit_defines.svh"

module cau_checker #(
	parameter int COMPONENT_WIDTH = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [COMPONENT_WIDTH-1:0] res_re,
	input logic [COMPONENT_WIDTH-1:0] res_im,
	input logic                       truth,
	input logic                       div_zero,
	input logic                       saturated
);

	`CAU_CHECK(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")
	`CAU_CHECK(a_dz_word, out_valid && div_zero, res_re == '0 && res_im == '0 && !saturated && !truth, "divide-by-zero word not clean")
	`CAU_CHECK(a_test_word, out_valid && truth, res_re == '0 && res_im == '0 && !saturated && !div_zero, "test word carries arithmetic fields")
	`CAU_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_re) && $stable(res_im), "stalled output word changed")

endmodule

bind complex_arithmetic_unit cau_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.res_re    (res_re),
	.res_im    (res_im),
	.truth     (truth),
	.div_zero  (div_zero),
	.saturated (saturated)
);
